FILE: design/flow_id_routing_table_top_assert.svh
// Assertion macros for the flow routing table.
`ifndef FLOW_ID_ROUTING_TABLE_TOP_ASSERT_SVH
`define FLOW_ID_ROUTING_TABLE_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FIRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FIRT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/firt_pkg.sv
// Shared types and constants of the flow routing table.
package firt_pkg;

	localparam int KEY_W    = 32;
	localparam int QUEUE_W  = 4;
	localparam int MASK_W   = 16;
	localparam int CNT_W    = 32;
	localparam int ACT_W    = 7;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

	// Queues that exist behind the ready mask
	localparam int QueueCount = 16;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 112;

	// Command codes carried in tuser
	localparam logic [CMD_W-1:0] CMD_ROUTE      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ROUTED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND   = 3'd6;

	localparam logic [ACT_W-1:0] LIMIT_RESET = 7'd64;

	// One table word
	typedef struct packed {
		logic               vld;
		logic [KEY_W-1:0]   key;
		logic [QUEUE_W-1:0] queue;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic clr_en;
		logic capture;
		logic scan_en;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic in_skip;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: design/flow_id_routing_table_top.sv
// Flow routing table: binds 32-bit keys to queue numbers and routes ticks by key.
// The table is a memory of TABLE_ENTRIES words that is searched one entry per
// clock, so every route, register or unregister item occupies the block from its
// acceptance until s_tready rises again (accept, one scan read of every entry,
// one compare drain, one commit); the commit waits further while the previous
// result is still held on the master side. An item with the undefined command
// code is accepted while the block stays idle and yields no result. After reset
// the block sweeps every table entry clear with s_tready low; limit writes are
// taken at any time.
module flow_id_routing_table_top #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// flow_key[31:0], target_queue[35:32], queue_ready_mask[51:36], zero pad
	input  logic [firt_pkg::IN_DATA_W-1:0]    s_tdata,
	// cmd[1:0]
	input  logic [firt_pkg::CMD_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], accepted[3], forward_valid[4], forward_queue[8:5],
	// routed_total[40:9], dropped_total[72:41], unknown_total[104:73],
	// active_entries[111:105]
	output logic [firt_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              limit_wr_en,
	input  logic [firt_pkg::ACT_W-1:0]        limit_wr_data
);
	import firt_pkg::*;

	`include "flow_id_routing_table_top_assert.svh"

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	firt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	firt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctrl_cmd),
		.stat          (dp_stat),
		.s_tuser       (s_tuser),
		.s_tdata       (s_tdata),
		.limit_wr_en   (limit_wr_en),
		.limit_wr_data (limit_wr_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

	// No input transfer while the table is being scanned
	`FIRT_ASSERT_ALWAYS(a_no_accept_in_scan, ctrl_cmd.scan_en |-> !s_tready, "input accepted during scan")

	// A forwarded tick is always an accepted route
	`FIRT_ASSERT(a_fwd_is_routed, (m_tvalid && m_tdata[4]) |-> (m_tdata[3] && m_tdata[2:0] == ST_ROUTED), "forward without routed status")

	// Accepted only for routed, registered or removed
	`FIRT_ASSERT(a_acc_status, (m_tvalid && m_tdata[3]) |-> (m_tdata[2:0] == ST_ROUTED || m_tdata[2:0] == ST_REGISTERED || m_tdata[2:0] == ST_REMOVED), "accepted with wrong status")

	// Active count never exceeds the table size
	`FIRT_ASSERT(a_active_bound, m_tvalid |-> (32'(m_tdata[111:105]) <= TABLE_ENTRIES), "active count beyond table size")

endmodule

FILE: design/firt_ctrl.sv
// Sequencer for table clearing, key scan and commit.
module firt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  firt_pkg::dp_stat_t  stat,
	output firt_pkg::ctrl_cmd_t cmd
);
	import firt_pkg::*;

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		SCAN,
		DRAIN,
		COMMIT
	} state_t;

	state_t state_q;

	// Decode commands from the current state
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			SCAN: begin
				cmd.scan_en = 1'b1;
			end
			COMMIT: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
		end else begin
			case (state_q)
				CLEAR: begin
					if (stat.clr_last) state_q <= IDLE;
				end
				IDLE: begin
					if (s_tvalid && !stat.in_skip) state_q <= SCAN;
				end
				SCAN: begin
					if (stat.scan_last) state_q <= DRAIN;
				end
				DRAIN: begin
					state_q <= COMMIT;
				end
				COMMIT: begin
					if (stat.out_free) state_q <= IDLE;
				end
				default: begin
					state_q <= CLEAR;
				end
			endcase
		end
	end

endmodule

FILE: design/firt_datapath.sv
// Table memory, scan compare, counters and result register.
module firt_datapath #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  firt_pkg::ctrl_cmd_t                 cmd,
	output firt_pkg::dp_stat_t                  stat,
	input  logic [firt_pkg::CMD_W-1:0]          s_tuser,
	input  logic [firt_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                limit_wr_en,
	input  logic [firt_pkg::ACT_W-1:0]          limit_wr_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [firt_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import firt_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	entry_t             mem_q [TABLE_ENTRIES];
	logic [AW-1:0]      ptr_q;
	entry_t             rdata_s1;
	logic [AW-1:0]      ridx_s1;
	logic               rvld_s1;

	logic [CMD_W-1:0]   cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [QUEUE_W-1:0] tq_q;
	logic [MASK_W-1:0]  mask_q;

	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic [QUEUE_W-1:0] hit_queue_q;
	logic               free_q;
	logic [AW-1:0]      free_idx_q;

	logic [ACT_W-1:0]   limit_q;
	logic [ACT_W-1:0]   active_q;
	logic [CNT_W-1:0]   routed_q;
	logic [CNT_W-1:0]   dropped_q;
	logic [CNT_W-1:0]   unknown_q;

	logic               out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic               match;
	logic               q_ready;
	logic               wr_req;
	logic [AW-1:0]      wr_idx;
	entry_t             wr_entry;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic [STATUS_W-1:0] res_status;
	logic               res_acc;
	logic               res_fwd;
	logic [QUEUE_W-1:0] res_fq;
	logic [ACT_W-1:0]   active_nx;
	logic [CNT_W-1:0]   routed_nx;
	logic [CNT_W-1:0]   dropped_nx;
	logic [CNT_W-1:0]   unknown_nx;

	// Status toward the controller
	always_comb begin
		stat.clr_last  = (ptr_q == LAST_IDX);
		stat.scan_last = (ptr_q == LAST_IDX);
		stat.in_skip   = !(s_tuser == CMD_ROUTE || s_tuser == CMD_REGISTER ||
			s_tuser == CMD_UNREGISTER);
		stat.out_free  = !out_vld_q || m_tready;
	end

	// Step the shared clear and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= cmd.scan_en;
			if (cmd.capture) begin
				ptr_q <= '0;
			end else if (cmd.clr_en || cmd.scan_en) begin
				ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
			end
		end
	end

	// Table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (cmd.scan_en) begin
			rdata_s1 <= mem_q[ptr_q];
			ridx_s1  <= ptr_q;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= s_tuser;
			key_q  <= s_tdata[KEY_W-1:0];
			tq_q   <= s_tdata[KEY_W +: QUEUE_W];
			mask_q <= s_tdata[KEY_W+QUEUE_W +: MASK_W];
		end
	end

	assign match = rdata_s1.vld && (rdata_s1.key == key_q);

	// Record the first matching entry and the first free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.capture) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rvld_s1) begin
			if (match && !hit_q) hit_q <= 1'b1;
			if (!rdata_s1.vld && !free_q) free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			if (match && !hit_q) begin
				hit_idx_q   <= ridx_s1;
				hit_queue_q <= rdata_s1.queue;
			end
			if (!rdata_s1.vld && !free_q) free_idx_q <= ridx_s1;
		end
	end

	assign q_ready = (32'(hit_queue_q) < QueueCount) && mask_q[hit_queue_q];

	// Resolve the item from the scan results
	always_comb begin
		res_status = ST_ROUTED;
		res_acc    = 1'b0;
		res_fwd    = 1'b0;
		res_fq     = '0;
		wr_req     = 1'b0;
		wr_idx     = hit_idx_q;
		wr_entry   = '{vld: 1'b1, key: key_q, queue: tq_q};
		active_nx  = active_q;
		routed_nx  = routed_q;
		dropped_nx = dropped_q;
		unknown_nx = unknown_q;
		case (cmd_q)
			CMD_ROUTE: begin
				if (!hit_q) begin
					res_status = ST_UNKNOWN;
					unknown_nx = (&unknown_q) ? unknown_q : unknown_q + CNT_W'(1);
				end else begin
					res_fq = hit_queue_q;
					if (q_ready) begin
						res_status = ST_ROUTED;
						res_acc    = 1'b1;
						res_fwd    = 1'b1;
						routed_nx  = (&routed_q) ? routed_q : routed_q + CNT_W'(1);
					end else begin
						res_status = ST_DROPPED;
						dropped_nx = (&dropped_q) ? dropped_q : dropped_q + CNT_W'(1);
					end
				end
			end
			CMD_REGISTER: begin
				if (active_q >= limit_q) begin
					res_status = ST_FULL;
				end else if (hit_q) begin
					res_status = ST_REGISTERED;
					res_acc    = 1'b1;
					wr_req     = 1'b1;
				end else if (free_q) begin
					res_status = ST_REGISTERED;
					res_acc    = 1'b1;
					wr_req     = 1'b1;
					wr_idx     = free_idx_q;
					active_nx  = active_q + ACT_W'(1);
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_UNREGISTER: begin
				if (hit_q) begin
					res_status   = ST_REMOVED;
					res_acc      = 1'b1;
					wr_req       = 1'b1;
					wr_entry.vld = 1'b0;
					active_nx    = (active_q != '0) ? active_q - ACT_W'(1) : active_q;
				end else begin
					res_status = ST_NOTFOUND;
				end
			end
			default: begin
				res_status = ST_NOTFOUND;
			end
		endcase
	end

	// Select the memory write source
	always_comb begin
		mem_we    = cmd.clr_en || (cmd.commit && wr_req);
		mem_waddr = cmd.clr_en ? ptr_q : wr_idx;
		mem_wdata = cmd.clr_en ? entry_t'('0) : wr_entry;
	end

	// Limit register, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			active_q  <= '0;
			routed_q  <= '0;
			dropped_q <= '0;
			unknown_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (limit_wr_en) limit_q <= limit_wr_data;
			if (cmd.commit) begin
				active_q  <= active_nx;
				routed_q  <= routed_nx;
				dropped_q <= dropped_nx;
				unknown_q <= unknown_nx;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {active_nx, unknown_nx, dropped_nx, routed_nx,
				res_fq, res_fwd, res_acc, res_status};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule
